// ----- rtl/u16550_pkg.sv -----
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types and constants of the 16550 register model: event kinds,
// register offsets, register bit indices and fixed status patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package u16550_pkg;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_RX    = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   localparam logic [7:0] REG_DATA    = 8'd0;
   localparam logic [7:0] REG_IER     = 8'd1;
   localparam logic [7:0] REG_IIR_FCR = 8'd2;
   localparam logic [7:0] REG_LCR     = 8'd3;
   localparam logic [7:0] REG_MCR     = 8'd4;
   localparam logic [7:0] REG_LSR     = 8'd5;
   localparam logic [7:0] REG_MSR     = 8'd6;
   localparam logic [7:0] REG_SCR     = 8'd7;

   localparam int unsigned LCR_DLAB_IDX = 7;
   localparam int unsigned MCR_LOOP_IDX = 4;
   localparam int unsigned IER_RX_IDX   = 0;
   localparam int unsigned IER_TX_IDX   = 1;
   localparam int unsigned FCR_EN_IDX   = 0;

   localparam logic [7:0] MCR_RESET     = 8'h08;
   localparam logic [7:0] IIR_RX        = 8'h04;
   localparam logic [7:0] IIR_TX        = 8'h02;
   localparam logic [7:0] IIR_NONE      = 8'h01;
   localparam logic [7:0] IIR_FIFO_TYPE = 8'hC0;
   localparam logic [7:0] LSR_IDLE      = 8'h60;
   localparam logic [7:0] LSR_READY     = 8'h01;
   localparam logic [7:0] MSR_FIXED     = 8'hB0;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   localparam int unsigned BYTES_PER_WORD = 4;
   localparam int unsigned LANE_W         = 2;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] reg_offset;
      logic [1:0] byte_lane;
      logic [7:0] write_byte;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        rx_dropped;
      logic        irq;
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [31:0] read_data;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/u16550_ram.sv -----
// ----------------------------------------------------------------------------
// u16550_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module u16550_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/uart_16550_register_model.sv -----
// ----------------------------------------------------------------------------
// uart_16550_register_model
// Register-level 16550 UART: bus reads and writes plus host receive bytes,
// with a receive FIFO, interrupt level and transmit byte output.
// ----------------------------------------------------------------------------
// Each transfer on req is one event (bus read, bus write, host receive byte
// or no-op, selected by req_tuser) and yields exactly one transfer on rsp.
// An event is registered on entry into the s1 register, decoded from there and
// applied to the register file and receive FIFO as it advances, and its
// response is registered; one event is taken every cycle while rsp_tready
// is high. The receive FIFO sits in a RAM with a registered read port that
// always prefetches the head entry, with a bypass for a push into the head
// slot, so a data-register pop completes in the same single pass. No
// clearing pass is needed after reset.
`default_nettype none

module uart_16550_register_model
   import u16550_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,   // lf_to_cr
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // reg_offset[7:0], byte_lane[9:8], write_byte[17:10], rx_byte[25:18]
   input  wire logic [31:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], tx_valid[32], tx_byte[40:33], irq[41], rx_dropped[42]
   output      logic [47:0] rsp_tdata
);

   localparam int unsigned ADDR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

   logic              lf_to_cr_ff;
   logic              s1_valid_ff;
   req_type           s1_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              advance;

   logic [7:0]        lcr_ff, lcr_in;
   logic [7:0]        mcr_ff, mcr_in;
   logic [7:0]        ier_ff, ier_in;
   logic [7:0]        fcr_ff, fcr_in;
   logic [7:0]        scr_ff, scr_in;
   logic [7:0]        dll_ff, dll_in;
   logic [7:0]        dlm_ff, dlm_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              txp_ff, txp_in;

   logic              push;
   logic [7:0]        push_data;
   logic [7:0]        ram_q;
   logic              fwd_valid_ff;
   logic [7:0]        fwd_data_ff;
   logic [7:0]        head;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};
   assign head       = fwd_valid_ff ? fwd_data_ff : ram_q;

   always_comb begin
      logic       dlab;
      logic       fifo_ne;
      logic [7:0] rbyte;
      logic [7:0] rval;
      logic [LANE_W-1:0] lane;

      dlab      = lcr_ff[LCR_DLAB_IDX];
      fifo_ne   = (fill_ff != '0);
      rbyte     = 8'd0;
      rval      = 8'd0;
      lane      = LANE_W'(s1_ff.byte_lane % BYTES_PER_WORD);
      lcr_in    = lcr_ff;
      mcr_in    = mcr_ff;
      ier_in    = ier_ff;
      fcr_in    = fcr_ff;
      scr_in    = scr_ff;
      dll_in    = dll_ff;
      dlm_in    = dlm_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      txp_in    = txp_ff;
      push      = 1'b0;
      push_data = s1_ff.rx_byte;
      rsp_in    = '0;

      if (advance) begin
         unique case (s1_ff.kind)
            KIND_READ: begin
               unique case (s1_ff.reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        rval = dll_ff;
                     end else if (fifo_ne) begin
                        rval      = head;
                        rd_ptr_in = (rd_ptr_ff == ADDR_W'(FIFO_DEPTH - 1)) ?
                                    '0 : rd_ptr_ff + 1'b1;
                        fill_in   = fill_ff - 1'b1;
                     end
                  end
                  REG_IER: rval = dlab ? dlm_ff : ier_ff;
                  REG_IIR_FCR: begin
                     if (ier_ff[IER_RX_IDX] && fifo_ne) begin
                        rval = IIR_RX;
                     end else if (ier_ff[IER_TX_IDX] && txp_ff) begin
                        rval   = IIR_TX;
                        txp_in = 1'b0;
                     end else begin
                        rval = IIR_NONE;
                     end
                     if (fcr_ff[FCR_EN_IDX]) begin
                        rval = rval | IIR_FIFO_TYPE;
                     end
                  end
                  REG_LCR: rval = lcr_ff;
                  REG_MCR: rval = mcr_ff;
                  REG_LSR: rval = fifo_ne ? (LSR_IDLE | LSR_READY) : LSR_IDLE;
                  REG_MSR: rval = MSR_FIXED;
                  REG_SCR: rval = scr_ff;
                  default: rval = 8'd0;
               endcase
               rsp_in.read_data = {24'd0, rval} << {lane, 3'b000};
            end
            KIND_WRITE: begin
               unique case (s1_ff.reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        dll_in = s1_ff.write_byte;
                     end else if (!mcr_ff[MCR_LOOP_IDX]) begin
                        rsp_in.tx_valid = 1'b1;
                        rsp_in.tx_byte  = s1_ff.write_byte;
                        txp_in          = 1'b1;
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        dlm_in = s1_ff.write_byte;
                     end else begin
                        ier_in = s1_ff.write_byte;
                     end
                  end
                  REG_IIR_FCR: fcr_in = s1_ff.write_byte;
                  REG_LCR:     lcr_in = s1_ff.write_byte;
                  REG_MCR:     mcr_in = s1_ff.write_byte;
                  REG_SCR:     scr_in = s1_ff.write_byte;
                  default:     rbyte  = 8'd0;
               endcase
            end
            KIND_RX: begin
               rbyte = (lf_to_cr_ff && s1_ff.rx_byte == CHAR_LF) ?
                       CHAR_CR : s1_ff.rx_byte;
               push_data = rbyte;
               if (fill_ff == FILL_W'(FIFO_DEPTH)) begin
                  rsp_in.rx_dropped = 1'b1;
               end else begin
                  push      = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == ADDR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            KIND_NOP: rbyte = 8'd0;
            default:  rbyte = 8'd0;
         endcase
         rsp_in.irq = (ier_in[IER_RX_IDX] && fill_in != '0) ||
                      (ier_in[IER_TX_IDX] && txp_in);
      end
   end

   u16550_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_to_cr_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lcr_ff       <= 8'd0;
         mcr_ff       <= MCR_RESET;
         ier_ff       <= 8'd0;
         fcr_ff       <= 8'd0;
         scr_ff       <= 8'd0;
         dll_ff       <= 8'd0;
         dlm_ff       <= 8'd0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         txp_ff       <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lf_to_cr_ff <= csr_wr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         lcr_ff       <= lcr_in;
         mcr_ff       <= mcr_in;
         ier_ff       <= ier_in;
         fcr_ff       <= fcr_in;
         scr_ff       <= scr_in;
         dll_ff       <= dll_in;
         dlm_ff       <= dlm_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         txp_ff       <= txp_in;
         fwd_valid_ff <= push && (wr_ptr_ff == rd_ptr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_ff.kind       <= kind_type'(req_tuser);
         s1_ff.reg_offset <= req_tdata[7:0];
         s1_ff.byte_lane  <= req_tdata[9:8];
         s1_ff.write_byte <= req_tdata[17:10];
         s1_ff.rx_byte    <= req_tdata[25:18];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      fwd_data_ff <= push_data;
   end

endmodule

`default_nettype wire

// ----- verif/tb_uart_16550_register_model.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_16550_register_model
// Self-checking bench for the 16550 register model. A short table of directed
// events covers reset values, undecoded offsets, ignored writes, loopback,
// divisor access and IIR priority. Random sequences follow: receive floods,
// FIFO drains, transmit bursts, status polling, register traffic and noise,
// over four phases that alternate the LF-to-CR mode. Every response transfer is
// compared field by field against an in-bench prediction of the registers.
// ----------------------------------------------------------------------------

module tb_uart_16550_register_model
   import u16550_pkg::*;
();

   localparam int FIFO_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 1500;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_AT      = 900;
   localparam int HOLD_CYCLES  = 150;
   localparam int PRINT_CAP    = 200;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  reg_offset;
      logic [1:0]  byte_lane;
      logic [7:0]  write_byte;
      logic [7:0]  rx_byte;
      bit          fixed_known;
      logic [31:0] fixed_read;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   // shadow copy of the register file and receive FIFO
   logic [7:0] line_ctl, modem_ctl, int_en, fifo_ctl, scratch_byte, div_lo, div_hi;
   logic [7:0] rx_queue_mem [FIFO_DEPTH];
   int         rx_head, rx_tail, rx_level;
   bit         tx_busy_flag;
   bit         lf_cr_mode;

   rsp_type    pending_outcomes [$];
   int         sent_count;
   int         checked_count;
   int         mismatch_count;
   bit         calm;

   dir_row_type directed_rows [30] = '{
      '{KIND_READ,  REG_MCR,     2'd0, 8'h00, 8'h00, 1'b1, 32'h0000_0008},
      '{KIND_READ,  REG_MSR,     2'd3, 8'h00, 8'h00, 1'b1, 32'hB000_0000},
      '{KIND_READ,  REG_IIR_FCR, 2'd1, 8'h00, 8'h00, 1'b1, 32'h0000_0100},
      '{KIND_READ,  REG_DATA,    2'd2, 8'h00, 8'h00, 1'b1, 32'h0000_0000},
      '{KIND_READ,  8'hFF,       2'd3, 8'h00, 8'h00, 1'b1, 32'h0000_0000},
      '{KIND_NOP,   8'hFF,       2'd3, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000},
      '{KIND_WRITE, 8'h80,       2'd0, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000},
      '{KIND_WRITE, REG_LSR,     2'd0, 8'hFF, 8'h00, 1'b1, 32'h0000_0000},
      '{KIND_WRITE, REG_MSR,     2'd0, 8'h00, 8'h00, 1'b1, 32'h0000_0000},
      '{KIND_WRITE, REG_SCR,     2'd0, 8'hFF, 8'h00, 1'b1, 32'h0000_0000},
      '{KIND_READ,  REG_SCR,     2'd1, 8'h00, 8'h00, 1'b1, 32'h0000_FF00},
      '{KIND_WRITE, REG_IER,     2'd0, 8'h03, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_DATA,    2'd0, 8'hFF, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_IIR_FCR, 2'd0, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_IIR_FCR, 2'd0, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_RX,    8'h00,       2'd0, 8'h00, CHAR_LF, 1'b0, 32'h0},
      '{KIND_RX,    8'h00,       2'd0, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_IIR_FCR, 2'd0, 8'h01, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_IIR_FCR, 2'd2, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_DATA,    2'd2, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_LCR,     2'd0, 8'h80, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_DATA,    2'd0, 8'h55, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_IER,     2'd0, 8'hAA, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_DATA,    2'd0, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_IER,     2'd3, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_LCR,     2'd0, 8'h00, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_MCR,     2'd0, 8'h10, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_DATA,    2'd0, 8'h33, 8'h00, 1'b0, 32'h0},
      '{KIND_WRITE, REG_MCR,     2'd0, 8'h08, 8'h00, 1'b0, 32'h0},
      '{KIND_READ,  REG_DATA,    2'd0, 8'h00, 8'h00, 1'b0, 32'h0}
   };

   uart_16550_register_model #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   function automatic logic [1:0] rnd2();
      return 2'($urandom);
   endfunction

   function automatic void reset_prediction();
      line_ctl     = '0;
      modem_ctl    = MCR_RESET;
      int_en       = '0;
      fifo_ctl     = '0;
      scratch_byte = '0;
      div_lo       = '0;
      div_hi       = '0;
      rx_head      = 0;
      rx_tail      = 0;
      rx_level     = 0;
      tx_busy_flag = 1'b0;
      lf_cr_mode   = 1'b0;
   endfunction

   // applies one event to the shadow registers and returns its response
   function automatic rsp_type apply_uart_event(req_type ev);
      rsp_type    r;
      logic [7:0] v;
      logic [7:0] b;
      bit         dlab;
      r    = '0;
      v    = '0;
      dlab = line_ctl[LCR_DLAB_IDX];
      case (ev.kind)
         KIND_READ: begin
            case (ev.reg_offset)
               REG_DATA: begin
                  if (dlab) begin
                     v = div_lo;
                  end else if (rx_level != 0) begin
                     v        = rx_queue_mem[rx_head];
                     rx_head  = (rx_head + 1) % FIFO_DEPTH;
                     rx_level = rx_level - 1;
                  end
               end
               REG_IER: v = dlab ? div_hi : int_en;
               REG_IIR_FCR: begin
                  if (int_en[IER_RX_IDX] && rx_level != 0) begin
                     v = IIR_RX;
                  end else if (int_en[IER_TX_IDX] && tx_busy_flag) begin
                     v            = IIR_TX;
                     tx_busy_flag = 1'b0;
                  end else begin
                     v = IIR_NONE;
                  end
                  if (fifo_ctl[FCR_EN_IDX]) v = v | IIR_FIFO_TYPE;
               end
               REG_LCR: v = line_ctl;
               REG_MCR: v = modem_ctl;
               REG_LSR: v = LSR_IDLE | ((rx_level != 0) ? LSR_READY : 8'h00);
               REG_MSR: v = MSR_FIXED;
               REG_SCR: v = scratch_byte;
               default: v = '0;
            endcase
            r.read_data = 32'(v) << (8 * (ev.byte_lane % BYTES_PER_WORD));
         end
         KIND_WRITE: begin
            case (ev.reg_offset)
               REG_DATA: begin
                  if (dlab) begin
                     div_lo = ev.write_byte;
                  end else if (!modem_ctl[MCR_LOOP_IDX]) begin
                     r.tx_valid   = 1'b1;
                     r.tx_byte    = ev.write_byte;
                     tx_busy_flag = 1'b1;
                  end
               end
               REG_IER: begin
                  if (dlab) div_hi = ev.write_byte;
                  else int_en = ev.write_byte;
               end
               REG_IIR_FCR: fifo_ctl     = ev.write_byte;
               REG_LCR:     line_ctl     = ev.write_byte;
               REG_MCR:     modem_ctl    = ev.write_byte;
               REG_SCR:     scratch_byte = ev.write_byte;
               default: ;
            endcase
         end
         KIND_RX: begin
            b = ev.rx_byte;
            if (lf_cr_mode && b == CHAR_LF) b = CHAR_CR;
            if (rx_level >= FIFO_DEPTH) begin
               r.rx_dropped = 1'b1;
            end else begin
               rx_queue_mem[rx_tail] = b;
               rx_tail  = (rx_tail + 1) % FIFO_DEPTH;
               rx_level = rx_level + 1;
            end
         end
         default: ;
      endcase
      r.irq = (int_en[IER_RX_IDX] && rx_level != 0) || (int_en[IER_TX_IDX] && tx_busy_flag);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("tb: mismatch in %s at response %0d: got %h, expected %h",
                  what, checked_count, got, want);
   endtask

   task automatic check_outcome(rsp_type got);
      rsp_type want;
      if (pending_outcomes.size() == 0) begin
         report_mismatch("unexpected transfer", got.read_data, '0);
         return;
      end
      want = pending_outcomes.pop_front();
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.tx_valid !== want.tx_valid)
         report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
         report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      if (got.irq !== want.irq)
         report_mismatch("irq", 32'(got.irq), 32'(want.irq));
      if (got.rx_dropped !== want.rx_dropped)
         report_mismatch("rx_dropped", 32'(got.rx_dropped), 32'(want.rx_dropped));
      checked_count++;
   endtask

   // offers one event and records its expected response once transferred
   task automatic push_req(input req_type ev, input bit fixed_known,
                           input logic [31:0] fixed_read);
      rsp_type outcome;
      while (!calm && ($urandom_range(99) < 12)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.kind;
      req_tdata  <= {6'b0, ev.rx_byte, ev.write_byte, ev.byte_lane, ev.reg_offset};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      outcome = apply_uart_event(ev);
      if (fixed_known) begin
         outcome           = '0;
         outcome.read_data = fixed_read;
      end
      pending_outcomes.insert(pending_outcomes.size(), outcome);
      sent_count++;
      calm = (sent_count >= 400) && (sent_count < 600);
   endtask

   task automatic issue(kind_type k, logic [7:0] off, logic [1:0] lane,
                        logic [7:0] wb, logic [7:0] rb);
      req_type ev;
      ev.kind       = k;
      ev.reg_offset = off;
      ev.byte_lane  = lane;
      ev.write_byte = wb;
      ev.rx_byte    = rb;
      push_req(ev, 1'b0, '0);
   endtask

   // only while drained; the wait also covers the block's pipeline registers
   task automatic set_lf_to_cr(bit value);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      lf_cr_mode = value;
   endtask

   task automatic run_random_sequence();
      int         pick;
      int         len;
      logic [7:0] off;
      logic [7:0] wb;
      pick = $urandom_range(99);
      if (pick < 25) begin
         len = ($urandom_range(9) == 0) ? 70 : $urandom_range(20, 1);
         repeat (len)
            issue(KIND_RX, rnd8(), rnd2(), rnd8(),
                  ($urandom_range(7) == 0) ? CHAR_LF : rnd8());
      end else if (pick < 45) begin
         repeat ($urandom_range(20, 1)) issue(KIND_READ, REG_DATA, rnd2(), rnd8(), rnd8());
      end else if (pick < 58) begin
         repeat ($urandom_range(8, 1)) issue(KIND_WRITE, REG_DATA, rnd2(), rnd8(), rnd8());
      end else if (pick < 72) begin
         issue(KIND_WRITE, REG_IER, rnd2(), rnd8(), rnd8());
         repeat ($urandom_range(4, 1)) begin
            off = ($urandom_range(1) == 0) ? REG_IIR_FCR : 8'($urandom_range(7));
            issue(KIND_READ, off, rnd2(), rnd8(), rnd8());
         end
      end else if (pick < 90) begin
         off = 8'($urandom_range(7));
         wb  = rnd8();
         issue(KIND_WRITE, off, rnd2(), wb, rnd8());
         issue(KIND_READ, off, rnd2(), rnd8(), rnd8());
         // mostly drop DLAB and loopback again so data traffic stays live
         if (off == REG_LCR && $urandom_range(4) != 0) begin
            wb[LCR_DLAB_IDX] = 1'b0;
            issue(KIND_WRITE, REG_LCR, rnd2(), wb, rnd8());
         end
         if (off == REG_MCR && $urandom_range(4) != 0) begin
            wb[MCR_LOOP_IDX] = 1'b0;
            issue(KIND_WRITE, REG_MCR, rnd2(), wb, rnd8());
         end
      end else begin
         repeat ($urandom_range(6, 1))
            issue(kind_type'($urandom_range(3)), rnd8(), rnd2(), rnd8(), rnd8());
      end
   endtask

   initial begin : response_side
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_outcome(rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
         if (!hold_done && checked_count >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 12);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      req_type ev;
      int      phase_start;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_NOP;
      sent_count     = 0;
      checked_count  = 0;
      mismatch_count = 0;
      calm           = 1'b0;
      reset_prediction();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_lf_to_cr(1'b0);
      foreach (directed_rows[i]) begin
         ev.kind       = directed_rows[i].kind;
         ev.reg_offset = directed_rows[i].reg_offset;
         ev.byte_lane  = directed_rows[i].byte_lane;
         ev.write_byte = directed_rows[i].write_byte;
         ev.rx_byte    = directed_rows[i].rx_byte;
         push_req(ev, directed_rows[i].fixed_known, directed_rows[i].fixed_read);
      end

      for (int phase = 0; phase < 4; phase++) begin
         set_lf_to_cr(phase % 2 == 0);
         phase_start = sent_count;
         while (sent_count - phase_start < RANDOM_ITEMS / 4) run_random_sequence();
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/u16550_pkg.sv
rtl/u16550_ram.sv
rtl/uart_16550_register_model.sv
verif/tb_uart_16550_register_model.sv
